### rtl/core/sbsc_pkg.sv
// ----------------------------------------------------------------------------
// sbsc_pkg
// shared types, constants, control word format and helpers of the servo
// backlash step controller
// ----------------------------------------------------------------------------
package sbsc_pkg;

  localparam int MAX_DELTA_DEF = 90;
  localparam int DELTA_CAP     = 99;   // keeps a run at 24 words or fewer
  localparam int STEP_SIZE     = 5;
  localparam int SERVO_TOP     = 180;
  localparam int START_POS     = 20;
  localparam int MAXDEV_RST    = 30;

  localparam int POS_W  = 8;
  localparam int DEV_W  = 10;
  localparam int REM_W  = 7;           // holds up to DELTA_CAP
  localparam int ST_W   = 2;
  localparam int PC_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEV    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOMED      = 2'd2;

  // command modes
  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_BACK = 2'd1;
  localparam logic [1:0] MODE_HOME = 2'd2;
  localparam logic [1:0] MODE_MOVE = 2'd3;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_LIMIT     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_HOMED = 2'd2;
  localparam logic [ST_W-1:0] ST_HOMED_CMD = 2'd3;

  // result kinds
  localparam logic KIND_POS    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2,
    DIR_HOME = 2'd3
  } dir_t;

  // datapath actions
  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_W_OS,
    ACT_W_STEP,
    ACT_W_REM,
    ACT_SET_LIMIT,
    ACT_W_HOME_OS,
    ACT_W_HOME,
    ACT_W_STATUS
  } act_t;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_HOMED,
    C_MODE_HOME,
    C_REM_LT5,
    C_NO_OS,
    C_REM_GE10,
    C_REM_ZERO,
    C_IN_LIMIT
  } cond_t;

  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic             done;
  } uword_t;

  // condition flags from the datapath
  typedef struct packed {
    logic not_homed;
    logic mode_home;
    logic rem_lt5;
    logic no_os;
    logic rem_ge10;
    logic rem_zero;
    logic in_limit;
    logic out_free;
  } dp_flags_t;

  // strobe from the sequencer
  typedef struct packed {
    logic fire;
    act_t act;
  } dp_ctrl_t;

  function automatic logic act_emits(act_t a);
    logic e;
    unique case (a)
      ACT_W_OS, ACT_W_STEP, ACT_W_REM,
      ACT_W_HOME_OS, ACT_W_HOME, ACT_W_STATUS: e = 1'b1;
      ACT_NOP, ACT_SET_LIMIT:                  e = 1'b0;
      default:                                 e = 1'b0;
    endcase
    return e;
  endfunction

  function automatic logic [POS_W-1:0] clamp_angle(logic signed [DEV_W-1:0] a);
    logic [POS_W-1:0] r;
    if (a < 0) r = '0;
    else if (a > DEV_W'(SERVO_TOP)) r = POS_W'(SERVO_TOP);
    else r = a[POS_W-1:0];
    return r;
  endfunction

endpackage

### rtl/core/sbsc_ucode_rom.sv
// ----------------------------------------------------------------------------
// sbsc_ucode_rom
// control program of the step controller, one control word per step
// ----------------------------------------------------------------------------
module sbsc_ucode_rom
  import sbsc_pkg::*;
(
  input  logic [PC_W-1:0] pc,
  output uword_t          uw
);

  localparam logic [PC_W-1:0] L_REM_TEST = 4'd6;
  localparam logic [PC_W-1:0] L_STEP     = 4'd5;
  localparam logic [PC_W-1:0] L_CHECK    = 4'd8;
  localparam logic [PC_W-1:0] L_HOME     = 4'd10;
  localparam logic [PC_W-1:0] L_FIN      = 4'd12;
  localparam logic [PC_W-1:0] L_START    = 4'd0;

  always_comb begin
    unique case (pc)
      4'd0:  uw = '{ACT_NOP,       C_NOT_HOMED, L_FIN,      1'b0};
      4'd1:  uw = '{ACT_NOP,       C_MODE_HOME, L_HOME,     1'b0};
      4'd2:  uw = '{ACT_NOP,       C_REM_LT5,   L_REM_TEST, 1'b0};
      4'd3:  uw = '{ACT_NOP,       C_NO_OS,     L_STEP,     1'b0};
      4'd4:  uw = '{ACT_W_OS,      C_NEVER,     L_START,    1'b0};
      4'd5:  uw = '{ACT_W_STEP,    C_REM_GE10,  L_STEP,     1'b0};
      4'd6:  uw = '{ACT_NOP,       C_REM_ZERO,  L_CHECK,    1'b0};
      4'd7:  uw = '{ACT_W_REM,     C_NEVER,     L_START,    1'b0};
      4'd8:  uw = '{ACT_NOP,       C_IN_LIMIT,  L_FIN,      1'b0};
      4'd9:  uw = '{ACT_SET_LIMIT, C_NEVER,     L_START,    1'b0};
      4'd10: uw = '{ACT_W_HOME_OS, C_NEVER,     L_START,    1'b0};
      4'd11: uw = '{ACT_W_HOME,    C_NEVER,     L_START,    1'b0};
      4'd12: uw = '{ACT_W_STATUS,  C_ALWAYS,    L_START,    1'b1};
      default: uw = '{ACT_NOP,     C_ALWAYS,    L_FIN,      1'b0};
    endcase
  end

endmodule

### rtl/core/sbsc_sequencer.sv
// ----------------------------------------------------------------------------
// sbsc_sequencer
// step counter with conditional jumps over the control program
// ----------------------------------------------------------------------------
module sbsc_sequencer
  import sbsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dp_flags_t flags,
  output logic      busy,
  output dp_ctrl_t  ctrl
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            busy_r, busy_nxt;
  uword_t          uw;
  logic            cond_hit;
  logic            fire;

  sbsc_ucode_rom u_rom (
    .pc (pc_r),
    .uw (uw)
  );

  always_comb begin
    unique case (uw.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_ALWAYS:    cond_hit = 1'b1;
      C_NOT_HOMED: cond_hit = flags.not_homed;
      C_MODE_HOME: cond_hit = flags.mode_home;
      C_REM_LT5:   cond_hit = flags.rem_lt5;
      C_NO_OS:     cond_hit = flags.no_os;
      C_REM_GE10:  cond_hit = flags.rem_ge10;
      C_REM_ZERO:  cond_hit = flags.rem_zero;
      C_IN_LIMIT:  cond_hit = flags.in_limit;
      default:     cond_hit = 1'b0;
    endcase
  end

  // an emitting step waits for room in the output register
  assign fire = busy_r && (!act_emits(uw.act) || flags.out_free);

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    priority if (start) begin
      pc_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (fire) begin
      if (uw.done) begin
        pc_nxt   = '0;
        busy_nxt = 1'b0;
      end else if (cond_hit) begin
        pc_nxt = uw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end else begin
      pc_nxt   = pc_r;
      busy_nxt = busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy      = busy_r;
  assign ctrl.fire = fire;
  assign ctrl.act  = uw.act;

endmodule

### rtl/core/sbsc_datapath.sv
// ----------------------------------------------------------------------------
// sbsc_datapath
// position, deviation and direction registers, configuration registers,
// command loading and the output register
// ----------------------------------------------------------------------------
module sbsc_datapath
  import sbsc_pkg::*;
#(
  parameter int MAX_DELTA = MAX_DELTA_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   load,
  input  logic [1:0]             mode,
  input  logic signed [7:0]      delta,
  input  dp_ctrl_t               ctrl,
  output dp_flags_t              flags,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_kind,
  output logic [POS_W-1:0]       out_position,
  output logic signed [DEV_W-1:0] out_deviation,
  output logic [ST_W-1:0]        out_status,
  output logic                   out_last
);

  localparam int LIM = (MAX_DELTA < DELTA_CAP) ? MAX_DELTA : DELTA_CAP;
  localparam logic signed [DEV_W-1:0] LIM_P = DEV_W'(LIM);
  localparam logic signed [DEV_W-1:0] LIM_N = -DEV_W'(LIM);
  localparam logic signed [DEV_W-1:0] STEP_D = DEV_W'(STEP_SIZE);
  localparam logic signed [DEV_W-1:0] OS_D   = DEV_W'(2 * STEP_SIZE);

  // configuration
  logic [POS_W-1:0] home_r;
  logic [7:0]       maxdev_r;
  logic             homed_r;

  // servo state
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [DEV_W-1:0] dev_r, dev_nxt;
  dir_t                    dir_r, dir_nxt;

  // current command
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic             fwd_r, fwd_nxt;
  logic [ST_W-1:0]  st_r, st_nxt;

  // output register
  logic                    ov_r, ov_nxt;
  logic                    okind_r;
  logic [POS_W-1:0]        opos_r;
  logic signed [DEV_W-1:0] odev_r;
  logic [ST_W-1:0]         ost_r;
  logic                    olast_r;

  logic signed [DEV_W-1:0] pos_s, step_s, os_s, rem_s, home_s;
  logic signed [DEV_W-1:0] d_ext, d_sat, md_s;
  logic                    emit;
  logic                    out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_r   <= '0;
      maxdev_r <= 8'(MAXDEV_RST);
      homed_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HOME_ANGLE: home_r   <= cfg_wdata;
        CFG_MAX_DEV:    maxdev_r <= cfg_wdata;
        CFG_HOMED:      homed_r  <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  assign pos_s  = DEV_W'(pos_r);
  assign step_s = fwd_r ? STEP_D : -STEP_D;
  assign os_s   = fwd_r ? OS_D : -OS_D;
  assign rem_s  = fwd_r ? DEV_W'(rem_r) : -DEV_W'(rem_r);
  assign home_s = DEV_W'(home_r);
  assign md_s   = DEV_W'(maxdev_r);

  // delta saturation at the load
  assign d_ext = DEV_W'(delta);
  always_comb begin
    priority if (d_ext > LIM_P) d_sat = LIM_P;
    else if (d_ext < LIM_N)     d_sat = LIM_N;
    else                        d_sat = d_ext;
  end

  assign out_free = !ov_r || out_ready;
  assign emit     = ctrl.fire && act_emits(ctrl.act);

  always_comb begin
    pos_nxt = pos_r;
    dev_nxt = dev_r;
    dir_nxt = dir_r;
    rem_nxt = rem_r;
    fwd_nxt = fwd_r;
    st_nxt  = st_r;
    if (load) begin
      unique case (mode)
        MODE_FWD: begin
          rem_nxt = REM_W'(STEP_SIZE);
          fwd_nxt = 1'b1;
        end
        MODE_BACK: begin
          rem_nxt = REM_W'(STEP_SIZE);
          fwd_nxt = 1'b0;
        end
        MODE_HOME: begin
          rem_nxt = '0;
          fwd_nxt = 1'b1;
        end
        MODE_MOVE: begin
          rem_nxt = (d_sat < 0) ? REM_W'(-d_sat) : REM_W'(d_sat);
          fwd_nxt = (d_sat > 0);
        end
        default: ;
      endcase
      priority if (!homed_r)       st_nxt = ST_NOT_HOMED;
      else if (mode == MODE_HOME)  st_nxt = ST_HOMED_CMD;
      else                         st_nxt = ST_OK;
    end else if (ctrl.fire) begin
      unique case (ctrl.act)
        ACT_W_OS: pos_nxt = clamp_angle(pos_s + os_s);
        ACT_W_STEP: begin
          pos_nxt = clamp_angle(pos_s + step_s);
          dev_nxt = dev_r + step_s;
          dir_nxt = fwd_r ? DIR_FWD : DIR_BACK;
          rem_nxt = rem_r - REM_W'(STEP_SIZE);
        end
        ACT_W_REM: begin
          pos_nxt = clamp_angle(pos_s + rem_s);
          dev_nxt = dev_r + rem_s;
          dir_nxt = fwd_r ? DIR_FWD : DIR_BACK;
          rem_nxt = '0;
        end
        ACT_SET_LIMIT: st_nxt = ST_LIMIT;
        ACT_W_HOME_OS: begin
          pos_nxt = clamp_angle(home_s + OS_D);
          dev_nxt = '0;
        end
        ACT_W_HOME: begin
          pos_nxt = clamp_angle(home_s);
          dir_nxt = DIR_HOME;
        end
        ACT_NOP, ACT_W_STATUS: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    if (emit)           ov_nxt = 1'b1;
    else if (out_ready) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_W'(START_POS);
      dev_r <= '0;
      dir_r <= DIR_NONE;
      ov_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      dev_r <= dev_nxt;
      dir_r <= dir_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    fwd_r <= fwd_nxt;
    st_r  <= st_nxt;
    if (emit) begin
      // a position word shows the state after its own write
      okind_r <= (ctrl.act == ACT_W_STATUS) ? KIND_STATUS : KIND_POS;
      opos_r  <= pos_nxt;
      odev_r  <= dev_nxt;
      ost_r   <= (ctrl.act == ACT_W_STATUS) ? st_r : ST_OK;
      olast_r <= (ctrl.act == ACT_W_STATUS);
    end
  end

  assign flags.not_homed = (st_r == ST_NOT_HOMED);
  assign flags.mode_home = (st_r == ST_HOMED_CMD);
  assign flags.rem_lt5   = (rem_r < REM_W'(STEP_SIZE));
  assign flags.no_os     = fwd_r ? (dir_r == DIR_FWD) : (dir_r != DIR_FWD);
  assign flags.rem_ge10  = (rem_r >= REM_W'(2 * STEP_SIZE));
  assign flags.rem_zero  = (rem_r == '0);
  assign flags.in_limit  = (dev_r <= md_s) && (dev_r >= -md_s);
  assign flags.out_free  = out_free;

  assign out_valid     = ov_r;
  assign out_kind      = okind_r;
  assign out_position  = opos_r;
  assign out_deviation = odev_r;
  assign out_status    = ost_r;
  assign out_last      = olast_r;

endmodule

### rtl/core/servo_backlash_step_controller.sv
// ----------------------------------------------------------------------------
// servo_backlash_step_controller
// servo stepping with backlash overshoot, deviation limit and return home
// ----------------------------------------------------------------------------
// One input word is one servo command. The block answers with a run of
// position words and ends every run with one status word (tuser high, tlast
// high). A command is taken only when the previous run has been fully
// produced; the run is driven by a 13-step control program, one step per
// cycle whether the step writes a word or only tests a condition, and a step
// that writes a word also waits out any cycles the output side stalls.
// The shortest path through the program is a command rejected while not
// homed, the longest a 99-degree move with overshoot, a remainder and a
// forced return home (reachable with MAX_DELTA of 99 or more); the next
// command is taken in the cycle after the last step of a run. The last
// status word may still wait in the output register while the next command
// is accepted. Configuration writes are meant to happen only while no run is
// in progress.
module servo_backlash_step_controller
  import sbsc_pkg::*;
#(
  parameter int MAX_DELTA = MAX_DELTA_DEF   // delta saturation, 5 to 180
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // command stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,    // mode[1:0], delta[9:2], zero pad
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,   // position[7:0], deviation[17:8],
                                             // status[19:18], zero pad
  output logic                  out_tuser,   // kind: 0 position, 1 status
  output logic                  out_tlast
);

  dp_flags_t               flags;
  dp_ctrl_t                ctrl;
  logic                    busy;
  logic                    in_acc;
  logic [POS_W-1:0]        position;
  logic signed [DEV_W-1:0] deviation;
  logic [ST_W-1:0]         status;

  // a new command waits until the current run is finished
  assign in_tready = !busy;
  assign in_acc    = in_tvalid && in_tready;

  sbsc_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .flags (flags),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  sbsc_datapath #(
    .MAX_DELTA (MAX_DELTA)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .load          (in_acc),
    .mode          (in_tdata[1:0]),
    .delta         (in_tdata[9:2]),
    .ctrl          (ctrl),
    .flags         (flags),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_kind      (out_tuser),
    .out_position  (position),
    .out_deviation (deviation),
    .out_status    (status),
    .out_last      (out_tlast)
  );

  // pack the result word, lowest field first
  assign out_tdata = {4'b0000, status, deviation, position};

endmodule

### tb/sbsc_score_pkg.sv
// ----------------------------------------------------------------------------
// sbsc_score_pkg
// predictor and result checker for the servo backlash step controller
// ----------------------------------------------------------------------------
package sbsc_score_pkg;

  import sbsc_pkg::*;

  // one result word as it leaves the block
  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] position;
    logic [DEV_W-1:0] deviation;
    logic [ST_W-1:0]  status;
    logic             last;
  } servo_word_t;

  class servo_scoreboard;

    // register copies
    int   home_angle;
    int   max_dev;
    bit   homed;
    // servo state
    int   pos;
    int   dev;
    dir_t dir;

    servo_word_t awaited[$];
    int unsigned mismatches;
    int unsigned words_seen;
    int unsigned forced_returns;
    int unsigned rejected;

    function new();
      home_angle = 0;
      max_dev    = MAXDEV_RST;
      homed      = 1'b0;
      pos        = START_POS;
      dev        = 0;
      dir        = DIR_NONE;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_HOME_ANGLE: home_angle = val;
        CFG_MAX_DEV:    max_dev    = val;
        CFG_HOMED:      homed      = val[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void push_word(logic kind, logic [ST_W-1:0] st, logic last);
      servo_word_t w;
      w.kind      = kind;
      w.position  = pos[POS_W-1:0];
      w.deviation = dev[DEV_W-1:0];
      w.status    = st;
      w.last      = last;
      awaited.push_back(w);
    endfunction

    // position write, clamped to the servo travel
    function void drive_to(int target);
      if (target < 0) pos = 0;
      else if (target > SERVO_TOP) pos = SERVO_TOP;
      else pos = target;
      push_word(KIND_POS, ST_OK, 1'b0);
    endfunction

    function void return_home();
      dev = 0;
      drive_to(home_angle + 2 * STEP_SIZE);
      drive_to(home_angle);
      dir = DIR_HOME;
    endfunction

    function void single_step(bit fwd);
      if (fwd) begin
        if (dir != DIR_FWD) drive_to(pos + 2 * STEP_SIZE);
        dev += STEP_SIZE;
        drive_to(pos + STEP_SIZE);
        dir = DIR_FWD;
      end else begin
        if (dir == DIR_FWD) drive_to(pos - 2 * STEP_SIZE);
        dev -= STEP_SIZE;
        drive_to(pos - STEP_SIZE);
        dir = DIR_BACK;
      end
    endfunction

    function void travel(int d);
      bit fwd;
      int rest;
      if (d == 0) return;
      fwd  = d > 0;
      rest = fwd ? d : -d;
      while (rest >= STEP_SIZE) begin
        single_step(fwd);
        rest -= STEP_SIZE;
      end
      if (rest > 0) begin
        dev += fwd ? rest : -rest;
        drive_to(pos + (fwd ? rest : -rest));
        dir = fwd ? DIR_FWD : DIR_BACK;
      end
    endfunction

    // expected run of words for one accepted command
    function void note_command(logic [1:0] mode, logic [7:0] delta);
      int d;
      int lim;
      d   = $signed(delta);
      lim = (MAX_DELTA_DEF < DELTA_CAP) ? MAX_DELTA_DEF : DELTA_CAP;
      if (!homed) begin
        rejected++;
        push_word(KIND_STATUS, ST_NOT_HOMED, 1'b1);
        return;
      end
      if (mode == MODE_HOME) begin
        return_home();
        push_word(KIND_STATUS, ST_HOMED_CMD, 1'b1);
        return;
      end
      case (mode)
        MODE_FWD:  travel(STEP_SIZE);
        MODE_BACK: travel(-STEP_SIZE);
        default: begin
          if (d > lim) d = lim;
          if (d < -lim) d = -lim;
          travel(d);
        end
      endcase
      if (dev > max_dev || dev < -max_dev) begin
        forced_returns++;
        return_home();
        push_word(KIND_STATUS, ST_LIMIT, 1'b1);
      end else begin
        push_word(KIND_STATUS, ST_OK, 1'b1);
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t mismatch: %s", $realtime, msg);
    endfunction

    function void check_word(servo_word_t got);
      servo_word_t want;
      words_seen++;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected word kind=%0d pos=%0d dev=%0d st=%0d last=%0d",
                       got.kind, got.position, $signed(got.deviation), got.status,
                       got.last));
        return;
      end
      want = awaited.pop_front();
      if (got !== want)
        flag($sformatf({"word %0d expected kind=%0d pos=%0d dev=%0d st=%0d last=%0d",
                        " got kind=%0d pos=%0d dev=%0d st=%0d last=%0d"},
                       words_seen, want.kind, want.position, $signed(want.deviation),
                       want.status, want.last, got.kind, got.position,
                       $signed(got.deviation), got.status, got.last));
    endfunction

  endclass

endpackage

### tb/servo_backlash_step_controller_tb.sv
// ----------------------------------------------------------------------------
// servo_backlash_step_controller_tb
// drives servo commands through several register settings and checks every
// position and status word against a cycle-free predictor of the controller
// ----------------------------------------------------------------------------
module servo_backlash_step_controller_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import sbsc_pkg::*;
  import sbsc_score_pkg::*;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_HOME_ANGLE;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;   // mode[1:0], delta[9:2], zero pad
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;         // position[7:0], deviation[17:8],
                                            // status[19:18], zero pad
  logic                  out_tuser;         // kind
  logic                  out_tlast;

  servo_scoreboard sb = new();

  bit          quiet;      // no idling on either side while set
  int unsigned commands_sent;

  servo_backlash_step_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // idle length: mostly none or short, now and then a long one
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // result side: ready bursts broken by stalls
  initial begin : ready_gen
    int burst;
    int gap;
    @(posedge clk);
    forever begin
      burst = quiet ? 30 : $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (burst) @(posedge clk);
      gap = next_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // every accepted word goes straight to the checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_word('{out_tuser, out_tdata[7:0], out_tdata[17:8], out_tdata[19:18],
                      out_tlast});
  end

  // one command word; valid stays high into the next call when no gap follows
  task automatic send_command(logic [1:0] mode, logic [7:0] delta);
    int gap;
    in_tdata  <= {6'b0, delta, mode};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_command(mode, delta);
    commands_sent++;
    gap = next_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain every outstanding run, then give the sequencer time to go idle
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(int home, int max_dev, bit is_homed);
    settle();
    write_reg(CFG_HOME_ANGLE, CFG_DATA_W'(home));
    write_reg(CFG_MAX_DEV, CFG_DATA_W'(max_dev));
    write_reg(CFG_HOMED, CFG_DATA_W'(is_homed));
  endtask

  // random command: mostly moves with small deltas, plus saturating ones
  task automatic random_command();
    int          r;
    logic [1:0]  mode;
    logic [7:0]  delta;
    logic [7:0]  edges[8];
    edges = '{8'sd127, 8'sd91, 8'sd90, 8'sd89, -8'sd89, -8'sd90, -8'sd91, 8'h80};
    r     = $urandom_range(0, 99);
    delta = 8'($urandom_range(0, 255));   // ignored outside move mode
    if (r < 20) mode = MODE_FWD;
    else if (r < 40) mode = MODE_BACK;
    else if (r < 48) mode = MODE_HOME;
    else begin
      mode = MODE_MOVE;
      r    = $urandom_range(0, 99);
      if (r < 60) delta = 8'($urandom_range(0, 40) - 20);
      else if (r < 85) delta = 8'($urandom_range(0, 255));
      else delta = edges[$urandom_range(0, 7)];
    end
    send_command(mode, delta);
  endtask

  task automatic random_phase(int count);
    repeat (count) random_command();
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // not homed after reset: every command is rejected
    send_command(MODE_FWD, 8'd0);
    send_command(MODE_MOVE, 8'sd90);

    // home in mid travel, wide limit
    configure(90, 180, 1'b1);
    send_command(MODE_HOME, 8'd0);
    send_command(MODE_FWD, 8'd0);          // overshoot after returning home
    send_command(MODE_FWD, 8'hff);         // no overshoot, delta ignored
    send_command(MODE_BACK, 8'd0);         // backlash on reversal
    send_command(MODE_BACK, 8'h7f);
    send_command(MODE_MOVE, 8'd0);         // zero delta, status only
    send_command(MODE_MOVE, 8'sd3);        // remainder only
    send_command(MODE_MOVE, -8'sd7);       // step plus remainder
    send_command(MODE_MOVE, 8'sd127);      // saturates
    send_command(MODE_MOVE, 8'h80);        // most negative delta
    send_command(MODE_MOVE, 8'sd90);
    send_command(MODE_MOVE, -8'sd90);
    send_command(MODE_MOVE, 8'sd1);
    send_command(MODE_MOVE, -8'sd1);
    send_command(MODE_MOVE, 8'sd90);       // with the next two, drives deviation past the limit
    send_command(MODE_MOVE, 8'sd90);
    send_command(MODE_MOVE, 8'sd90);

    // home beyond travel, zero limit: any step forces a clamped return
    configure(255, 0, 1'b1);
    send_command(MODE_FWD, 8'd0);
    send_command(MODE_MOVE, 8'd0);         // deviation equal to limit stays

    // random part across register settings
    configure(90, 30, 1'b1);
    random_phase(90);
    configure(0, 0, 1'b1);
    random_phase(50);
    configure(180, 180, 1'b1);
    quiet = 1'b1;                          // back-to-back stretch
    random_phase(80);
    quiet = 1'b0;
    configure(255, 255, 1'b1);
    random_phase(60);
    configure(45, 10, 1'b0);
    random_phase(20);
    configure($urandom_range(0, 180), $urandom_range(0, 100), 1'b1);
    random_phase(90);

    settle();
    $display("%0d commands sent, %0d rejected, %0d forced returns home",
             commands_sent, sb.rejected, sb.forced_returns);
    $display("%0d result words checked, %0d mismatches", sb.words_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("servo_backlash_step_controller_tb passed");
    end else begin
      $display("servo_backlash_step_controller_tb failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d words still awaited", sb.pending());
    $display("servo_backlash_step_controller_tb failed");
    $finish;
  end

endmodule
